// ===== src/pifwrl_pkg.sv =====
// Shared constants, types and codes for the per-id fixed window rate limiter.
`default_nettype none
package pifwrl_pkg;

  localparam int BUCKETS = 32;
  localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  localparam int ID_W = 32;
  localparam int TIME_W = 64;
  localparam int CNT_W = 4;
  localparam int WIN_W = 32;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ATTEMPT_LIMIT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 4'd8;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd60000000;

  localparam logic [1:0] OUTCOME_COUNTED = 2'd0;
  localparam logic [1:0] OUTCOME_NEW = 2'd1;
  localparam logic [1:0] OUTCOME_REFUSED = 2'd2;
  localparam logic [1:0] OUTCOME_FULL = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   owner;
    logic [TIME_W-1:0] start;
    logic [CNT_W-1:0]  count;
  } bucket_t;

  localparam int ENTRY_W = $bits(bucket_t);

  typedef struct packed {
    logic expired;
    logic live;
    logic owner_hit;
  } eval_t;

endpackage
`default_nettype wire

// ===== src/pifwrl_if.sv =====
// Valid/ready channel interfaces for attempt beats and result beats.
`default_nettype none
interface pifwrl_req_if import pifwrl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   requester_id;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, output requester_id, output now_time, input ready);
  modport sink (input valid, input requester_id, input now_time, output ready);
endinterface

interface pifwrl_res_if import pifwrl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       refused;
  logic [1:0] outcome;

  modport source (output valid, output refused, output outcome, input ready);
  modport sink (input valid, input refused, input outcome, output ready);
endinterface
`default_nettype wire

// ===== src/pifwrl_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module pifwrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/pifwrl_bucket_eval.sv =====
// Shared per-bucket unit: window expiry subtract and compare, and owner compare.
`default_nettype none
module pifwrl_bucket_eval import pifwrl_pkg::*; (
  input  wire logic [CNT_W-1:0]  count,
  input  wire logic [ID_W-1:0]   owner,
  input  wire logic [TIME_W-1:0] start,
  input  wire logic [TIME_W-1:0] now_time,
  input  wire logic [ID_W-1:0]   requester_id,
  input  wire logic [WIN_W-1:0]  window_length,
  output eval_t                  result
);
  logic [TIME_W-1:0] elapsed;
  logic              used;

  always_comb begin
    elapsed = now_time - start;
    used = (count != '0);
    result.expired = used && (elapsed >= TIME_W'(window_length));
    result.live = used && !result.expired;
    result.owner_hit = (owner == requester_id);
  end
endmodule
`default_nettype wire

// ===== src/per_id_fixed_window_rate_limiter.sv =====
// Top level: bucket table, scan sequencer and result register of the rate limiter.
// An attempt beat is taken only while the scan sequencer is idle.
// Each attempt scans the BUCKETS entries one per cycle through a single table read port.
// The result beat is registered as the sequencer leaves its update step, which waits while an earlier result is held.
// A new attempt beat is not accepted until the previous attempt has left the update step.
// Synchronous reset restores the control and configuration registers and frees all buckets.
`default_nettype none
module per_id_fixed_window_rate_limiter import pifwrl_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  pifwrl_req_if.sink                  req,
  pifwrl_res_if.source                res,
  input  wire logic                   cfg_write_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS - 1);

  logic [1:0]         state;
  logic [IDX_W-1:0]   scan_idx;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  logic [ID_W-1:0]    cur_id;
  logic [TIME_W-1:0]  cur_now;
  logic [CNT_W-1:0]   attempt_limit;
  logic [WIN_W-1:0]   window_length;
  logic [BUCKETS-1:0] bucket_valid;
  logic               match_hit;
  logic [IDX_W-1:0]   match_idx;
  logic [CNT_W-1:0]   match_count;
  logic [TIME_W-1:0]  match_start;
  logic               free_hit;
  logic [IDX_W-1:0]   free_idx;
  logic               res_valid;
  logic               res_refused;
  logic [1:0]         res_outcome;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  bucket_t            ram_wentry;
  bucket_t            rd_entry;
  logic [CNT_W-1:0]   ent_count;
  eval_t              ev;
  logic               out_free;
  logic [1:0]         outcome_next;

  pifwrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BUCKETS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (scan_idx),
    .rdata (rd_entry)
  );

  assign ent_count = bucket_valid[pend_idx] ? rd_entry.count : '0;

  pifwrl_bucket_eval u_eval (
    .count         (ent_count),
    .owner         (rd_entry.owner),
    .start         (rd_entry.start),
    .now_time      (cur_now),
    .requester_id  (cur_id),
    .window_length (window_length),
    .result        (ev)
  );

  assign req.ready = (state == ST_IDLE);
  assign res.valid = res_valid;
  assign res.refused = res_refused;
  assign res.outcome = res_outcome;
  assign out_free = !res_valid || res.ready;

  always_comb begin
    if (match_hit) begin
      outcome_next = (match_count >= attempt_limit) ? OUTCOME_REFUSED : OUTCOME_COUNTED;
    end else if (free_hit) begin
      outcome_next = OUTCOME_NEW;
    end else begin
      outcome_next = OUTCOME_FULL;
    end
    ram_we = (state == ST_UPDATE) && out_free &&
             ((outcome_next == OUTCOME_COUNTED) || (outcome_next == OUTCOME_NEW));
    ram_waddr = match_hit ? match_idx : free_idx;
    ram_wentry.owner = cur_id;
    ram_wentry.start = match_hit ? match_start : cur_now;
    ram_wentry.count = match_hit ? (match_count + CNT_W'(1)) : CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scan_idx <= '0;
      pend <= 1'b0;
      bucket_valid <= '0;
      attempt_limit <= LIMIT_RESET;
      window_length <= WINDOW_RESET;
      match_hit <= 1'b0;
      free_hit <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_ATTEMPT_LIMIT: attempt_limit <= cfg_data[CNT_W-1:0];
          REG_WINDOW_LENGTH: window_length <= cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end

      if ((state == ST_UPDATE) && out_free) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end

      pend <= (state == ST_SCAN);

      if (pend) begin
        if (ev.expired) begin
          bucket_valid[pend_idx] <= 1'b0;
        end
        if (ev.live && ev.owner_hit) begin
          match_hit <= 1'b1;
          match_idx <= pend_idx;
          match_count <= ent_count;
          match_start <= rd_entry.start;
        end else if (!ev.live && !free_hit) begin
          free_hit <= 1'b1;
          free_idx <= pend_idx;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cur_id <= req.requester_id;
            cur_now <= req.now_time;
            match_hit <= 1'b0;
            free_hit <= 1'b0;
            scan_idx <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_idx <= scan_idx;
          if (scan_idx == LAST_IDX) begin
            state <= ST_LAST;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        ST_LAST: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            res_refused <= (outcome_next == OUTCOME_REFUSED);
            res_outcome <= outcome_next;
            if (outcome_next == OUTCOME_NEW) begin
              bucket_valid[free_idx] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_SCAN && scan_idx == '0))
    else $error("accepted attempt did not start a scan at bucket zero");

  a_scan_pipeline: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (pend == (scan_idx != '0)))
    else $error("table read pipeline out of step with the scan index");

  a_update_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> !pend)
    else $error("bucket evaluation still pending at update");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_UPDATE))
    else $error("result beat raised outside the update step");

  a_write_has_target: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (match_hit || free_hit))
    else $error("table written with neither a matching nor a free bucket");
endmodule
`default_nettype wire
